@@ rtl/core/ipv4_packet_stream_summary_unit_macros.svh @@
// assertion macros for the ipv4 packet stream summary unit
// used by the parser and result buffer modules, no other dependencies
`ifndef IPV4_PACKET_STREAM_SUMMARY_UNIT_MACROS_SVH
`define IPV4_PACKET_STREAM_SUMMARY_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IPSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipss assertion failed");

// next-cycle implication, checked out of reset
`define IPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipss assertion failed");

`endif

@@ rtl/core/ipss_pkg.sv @@
// shared constants and types for the ipv4 packet stream summary unit
// no dependencies
`timescale 1ns / 1ps

package ipss_pkg;

    localparam int COUNT_BITS = 16;
    localparam int POS_BITS   = 16;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]   POS_MAX = {POS_BITS{1'b1}};

    localparam logic [POS_BITS-1:0] POS_IHL       = POS_BITS'(0);
    localparam logic [POS_BITS-1:0] POS_LEN_HI    = POS_BITS'(2);
    localparam logic [POS_BITS-1:0] POS_LEN_LO    = POS_BITS'(3);
    localparam logic [POS_BITS-1:0] POS_SRC_FIRST = POS_BITS'(12);
    localparam logic [POS_BITS-1:0] POS_SRC_LAST  = POS_BITS'(15);
    localparam logic [POS_BITS-1:0] POS_DST_FIRST = POS_BITS'(16);
    localparam logic [POS_BITS-1:0] POS_DST_LAST  = POS_BITS'(19);
    localparam logic [POS_BITS-1:0] TCP_OFS_BASE  = POS_BITS'(12);
    localparam logic [POS_BITS:0]   MIN_LENGTH    = (POS_BITS+1)'(4);

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [3:0]  header_words;
        logic [15:0] first_total_length;
        logic [3:0]  tcp_header_words;
        logic [15:0] packets_seen;
        logic        malformed;
    } t_summary;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

@@ rtl/core/ipss_byte_if.sv @@
// byte stream channel: valid/ready handshake with data byte and last flag
// no dependencies
`timescale 1ns / 1ps

interface ipss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/ipss_summary_if.sv @@
// summary channel: valid/ready handshake with the per-capture summary fields
// no dependencies
`timescale 1ns / 1ps

interface ipss_summary_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [3:0]  header_words;
    logic [15:0] first_total_length;
    logic [3:0]  tcp_header_words;
    logic [15:0] packets_seen;
    logic        malformed;

    modport source (
        output valid, output source_address, output dest_address, output header_words,
        output first_total_length, output tcp_header_words, output packets_seen,
        output malformed, input ready
    );
    modport sink (
        input valid, input source_address, input dest_address, input header_words,
        input first_total_length, input tcp_header_words, input packets_seen,
        input malformed, output ready
    );
endinterface

@@ rtl/core/ipss_parser.sv @@
// per-byte packet tracking and first-packet field capture
// depends on ipss_pkg and the ipss macros header
`timescale 1ns / 1ps
`include "ipv4_packet_stream_summary_unit_macros.svh"

module ipss_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output ipss_pkg::t_summary   o_summary
);

    logic [ipss_pkg::POS_BITS-1:0]   r_pos, n_pos;
    logic [15:0]                     r_len, n_len;
    logic [ipss_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                            r_first, n_first;
    logic [31:0]                     r_src, n_src;
    logic [31:0]                     r_dst, n_dst;
    logic [3:0]                      r_ihl, n_ihl;
    logic [15:0]                     r_flen, n_flen;
    logic [3:0]                      r_tcp, n_tcp;
    logic                            r_err, n_err;
    logic [ipss_pkg::POS_BITS:0]     pos_inc;
    logic [ipss_pkg::POS_BITS-1:0]   tcp_pos;

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_src   = r_src;
        n_dst   = r_dst;
        n_ihl   = r_ihl;
        n_flen  = r_flen;
        n_tcp   = r_tcp;
        n_err   = r_err;
        tcp_pos = ipss_pkg::POS_BITS'({r_ihl, 2'b00}) + ipss_pkg::TCP_OFS_BASE;

        if (r_pos == ipss_pkg::POS_IHL && !r_err && r_cnt != ipss_pkg::CNT_MAX) begin
            n_cnt = r_cnt + 1'b1;
        end

        if (r_first) begin
            if (r_pos == ipss_pkg::POS_IHL) begin
                n_ihl = i_byte[3:0];
            end else if (r_pos == ipss_pkg::POS_LEN_HI) begin
                n_flen[15:8] = i_byte;
            end else if (r_pos == ipss_pkg::POS_LEN_LO) begin
                n_flen[7:0] = i_byte;
            end else if (r_pos inside {[ipss_pkg::POS_SRC_FIRST:ipss_pkg::POS_SRC_LAST]}) begin
                n_src = {r_src[23:0], i_byte};
            end else if (r_pos inside {[ipss_pkg::POS_DST_FIRST:ipss_pkg::POS_DST_LAST]}) begin
                n_dst = {r_dst[23:0], i_byte};
            end
            if (r_pos == tcp_pos) begin
                n_tcp = i_byte[7:4];
            end
        end

        if (r_pos == ipss_pkg::POS_LEN_HI) begin
            n_len = {i_byte, 8'h00};
        end else if (r_pos == ipss_pkg::POS_LEN_LO) begin
            n_len = {r_len[15:8], i_byte};
            if ({1'b0, n_len} < ipss_pkg::MIN_LENGTH) begin
                n_err = 1'b1;
            end
        end

        pos_inc = {1'b0, r_pos} + 1'b1;
        if (!n_err && pos_inc >= ipss_pkg::MIN_LENGTH && pos_inc >= {1'b0, n_len}) begin
            n_pos   = '0;
            n_first = 1'b0;
        end else begin
            n_pos = pos_inc[ipss_pkg::POS_BITS] ? ipss_pkg::POS_MAX
                                                : pos_inc[ipss_pkg::POS_BITS-1:0];
        end
    end

    always_comb begin
        o_summary.source_address     = n_src;
        o_summary.dest_address       = n_dst;
        o_summary.header_words       = n_ihl;
        o_summary.first_total_length = n_flen;
        o_summary.tcp_header_words   = n_tcp;
        o_summary.packets_seen       = 16'(n_cnt);
        o_summary.malformed          = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_first <= 1'b1;
            r_src   <= '0;
            r_dst   <= '0;
            r_ihl   <= '0;
            r_flen  <= '0;
            r_tcp   <= '0;
            r_err   <= 1'b0;
        end else if (i_valid) begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_ihl   <= n_ihl;
            r_flen  <= n_flen;
            r_tcp   <= n_tcp;
            r_err   <= n_err;
        end
    end

    `IPSS_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, i_valid && i_last, r_pos == '0 && r_first && r_cnt == '0)
    `IPSS_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_err && !(i_valid && i_last), r_err)
    `IPSS_ASSERT_NEXT(a_idle_holds_count, i_clk, i_rst_n, !i_valid, $stable(r_cnt) && $stable(r_pos))

endmodule

@@ rtl/core/ipss_result_buf.sv @@
// two-entry result buffer (output register plus skid register) for summaries
// depends on ipss_pkg, ipss_summary_if and the ipss macros header
`timescale 1ns / 1ps
`include "ipv4_packet_stream_summary_unit_macros.svh"

module ipss_result_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ipss_pkg::t_summary     i_data,
    output ipss_pkg::t_buf_status  o_status,
    ipss_summary_if.source         o_sum
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    ipss_pkg::t_summary r_out_data, n_out_data;
    ipss_pkg::t_summary r_skid_data, n_skid_data;
    logic               pop;

    assign pop = r_out_valid && o_sum.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = i_push;
                n_skid_data  = i_data;
            end else begin
                n_out_valid = i_push;
                n_out_data  = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_status.out_valid  = r_out_valid;
    assign o_status.skid_valid = r_skid_valid;

    assign o_sum.valid              = r_out_valid;
    assign o_sum.source_address     = r_out_data.source_address;
    assign o_sum.dest_address       = r_out_data.dest_address;
    assign o_sum.header_words       = r_out_data.header_words;
    assign o_sum.first_total_length = r_out_data.first_total_length;
    assign o_sum.tcp_header_words   = r_out_data.tcp_header_words;
    assign o_sum.packets_seen       = r_out_data.packets_seen;
    assign o_sum.malformed          = r_out_data.malformed;

    `IPSS_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `IPSS_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, r_skid_valid && !pop, !i_push)

endmodule

@@ rtl/core/ipv4_packet_stream_summary_unit.sv @@
// summary path: the last byte is registered in the input register, then in the result buffer until taken
// throughput: one byte per cycle; input stalls while two summaries are held or in flight
// the per-byte state update is one pass from the input register into the parser state
// reset: synchronous active-low i_rst_n clears the byte pipeline and both result slots
// depends on ipss_pkg, ipss_byte_if, ipss_summary_if, ipss_parser, ipss_result_buf
`timescale 1ns / 1ps

module ipv4_packet_stream_summary_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipss_byte_if.sink      i_byte,
    ipss_summary_if.source o_summary
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    ipss_pkg::t_summary    step_summary;
    ipss_pkg::t_buf_status buf_status;
    logic [2:0]            slots_used;
    logic                  in_take;

    // slots committed after this edge: buffered results plus a pending last byte
    assign slots_used = {2'b00, buf_status.out_valid} + {2'b00, buf_status.skid_valid}
                      + {2'b00, r_in_valid && r_in_last}
                      - {2'b00, buf_status.out_valid && o_summary.ready};
    assign i_byte.ready = slots_used < 3'd2;
    assign in_take      = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= i_byte.data_byte;
        r_in_last <= i_byte.last_byte;
    end

    ipss_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_summary (step_summary)
    );

    ipss_result_buf u_result_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_in_valid && r_in_last),
        .i_data   (step_summary),
        .o_status (buf_status),
        .o_sum    (o_summary)
    );

endmodule

@@ dv/ipss_summary_checker.sv @@
// checker for the ipv4 packet stream summary unit: watches both channels,
// predicts each summary from the accepted bytes and compares field by field
// depends on ipss_pkg, ipss_byte_if, ipss_summary_if
`timescale 1ns / 1ps

module ipss_summary_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ipss_byte_if    i_byte_mon,
    ipss_summary_if i_summary_mon,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);

    localparam logic [15:0] POS_HDR_LEN = 16'd0;
    localparam logic [15:0] POS_TOT_HI  = 16'd2;
    localparam logic [15:0] POS_TOT_LO  = 16'd3;
    localparam logic [15:0] POS_SRC     = 16'd12;
    localparam logic [15:0] POS_DST     = 16'd16;
    localparam logic [15:0] POS_ADDR_END = 16'd20;
    localparam logic [15:0] TCP_BASE    = 16'd12;
    localparam logic [16:0] MIN_LEN     = 17'd4;
    localparam logic [16:0] POS_SAT     = 17'h0ffff;
    localparam logic [ipss_pkg::COUNT_BITS-1:0] PKT_CNT_SAT = {ipss_pkg::COUNT_BITS{1'b1}};

    logic [15:0]                     pos;
    logic [15:0]                     cur_len;
    logic [ipss_pkg::COUNT_BITS-1:0] pkt_count;
    logic                            in_first;
    logic [31:0]                     src_addr;
    logic [31:0]                     dst_addr;
    logic [3:0]                      ihl;
    logic [15:0]                     first_len;
    logic [3:0]                      tcp_ofs;
    logic                            len_error;

    ipss_pkg::t_summary summaries_due[$];
    int       fail_total = 0;
    int       checked_total = 0;
    int       due_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;
    assign o_checked    = checked_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("summary %0d %s: got %0h, expected %0h",
                                      checked_total, name, got, want));
        end
    endtask

    task automatic clear_parser();
        pos       = '0;
        cur_len   = '0;
        pkt_count = '0;
        in_first  = 1'b1;
        src_addr  = '0;
        dst_addr  = '0;
        ihl       = '0;
        first_len = '0;
        tcp_ofs   = '0;
        len_error = 1'b0;
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, input logic lst);
        logic [16:0]        nxt;
        ipss_pkg::t_summary s;
        if (pos == POS_HDR_LEN && !len_error && pkt_count != PKT_CNT_SAT) begin
            pkt_count = pkt_count + 1'b1;
        end
        if (in_first) begin
            if (pos == POS_HDR_LEN) begin
                ihl = b[3:0];
            end else if (pos == POS_TOT_HI) begin
                first_len[15:8] = b;
            end else if (pos == POS_TOT_LO) begin
                first_len[7:0] = b;
            end else if (pos >= POS_SRC && pos < POS_DST) begin
                src_addr = {src_addr[23:0], b};
            end else if (pos >= POS_DST && pos < POS_ADDR_END) begin
                dst_addr = {dst_addr[23:0], b};
            end
            // tcp data offset sits twelve bytes past the end of the ip header
            if (pos >= TCP_BASE && pos == (16'(ihl) << 2) + TCP_BASE) begin
                tcp_ofs = b[7:4];
            end
        end
        if (pos == POS_TOT_HI) begin
            cur_len = {b, 8'h00};
        end else if (pos == POS_TOT_LO) begin
            cur_len[7:0] = b;
            if (17'(cur_len) < MIN_LEN) begin
                len_error = 1'b1;
            end
        end
        nxt = 17'(pos) + 17'd1;
        if (!len_error && nxt >= MIN_LEN && nxt >= 17'(cur_len)) begin
            pos      = '0;
            in_first = 1'b0;
        end else begin
            pos = (nxt > POS_SAT) ? POS_SAT[15:0] : nxt[15:0];
        end
        if (lst) begin
            s.source_address     = src_addr;
            s.dest_address       = dst_addr;
            s.header_words       = ihl;
            s.first_total_length = first_len;
            s.tcp_header_words   = tcp_ofs;
            s.packets_seen       = 16'(pkt_count);
            s.malformed          = len_error;
            summaries_due.push_back(s);
            clear_parser();
        end
    endtask

    task automatic check_summary();
        ipss_pkg::t_summary want;
        if (summaries_due.size() == 0) begin
            report_mismatch($sformatf("summary %0d arrived with none expected", checked_total));
            checked_total++;
            return;
        end
        want = summaries_due.pop_front();
        compare_field("source_address", i_summary_mon.source_address, want.source_address);
        compare_field("dest_address", i_summary_mon.dest_address, want.dest_address);
        compare_field("header_words", i_summary_mon.header_words, want.header_words);
        compare_field("first_total_length", i_summary_mon.first_total_length,
                      want.first_total_length);
        compare_field("tcp_header_words", i_summary_mon.tcp_header_words,
                      want.tcp_header_words);
        compare_field("packets_seen", i_summary_mon.packets_seen, want.packets_seen);
        compare_field("malformed", i_summary_mon.malformed, want.malformed);
        checked_total++;
    endtask

    // a transaction counts only when valid and ready are both high at the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            summaries_due.delete();
        end else begin
            if (i_summary_mon.valid === 1'b1 && i_summary_mon.ready === 1'b1) begin
                check_summary();
            end
            if (i_byte_mon.valid === 1'b1 && i_byte_mon.ready === 1'b1) begin
                parse_stream_byte(i_byte_mon.data_byte, i_byte_mon.last_byte);
            end
        end
        due_count = summaries_due.size();
    end

endmodule

@@ dv/tb_ipv4_packet_stream_summary_unit.sv @@
// testbench top for the ipv4 packet stream summary unit: clock, reset, byte
// stimulus, summary back-pressure, watchdog and verdict
// depends on ipss_pkg, ipss_byte_if, ipss_summary_if, ipss_summary_checker and the rtl
`timescale 1ns / 1ps

module tb_ipv4_packet_stream_summary_unit;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 37;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int RAND_BYTES     = 1550;
    localparam int RAND_SUMMARIES = 12;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NOIDLE_PACKETS = 30;
    localparam int BAD_LEN_FILL   = 40;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    bit   rx_hold_req;
    int   stuck_cycles = 0;
    int   bytes_sent = 0;
    int   captures_sent = 0;
    int   mismatches;
    int   summaries_pending;
    int   summaries_checked;

    logic [7:0] capture_bytes[$];

    ipss_byte_if    byte_ch ();
    ipss_summary_if sum_ch ();

    ipv4_packet_stream_summary_unit uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_byte    (byte_ch),
        .o_summary (sum_ch)
    );

    ipss_summary_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_byte_mon    (byte_ch),
        .i_summary_mon (sum_ch),
        .o_fail_count  (mismatches),
        .o_pending     (summaries_pending),
        .o_checked     (summaries_checked)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (sum_ch.valid && sum_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("[ipv4_packet_stream_summary_unit] ERROR");
                $finish;
            end
        end
    end

    // summary receiver: random stalls while idling is on, plus one long hold on request
    initial begin
        sum_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                sum_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            sum_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_capture();
        foreach (capture_bytes[i]) begin
            send_byte(capture_bytes[i], i == capture_bytes.size() - 1);
        end
        captures_sent++;
    endtask

    task automatic send_header_and_fill(input logic [15:0] total_len, input int fill,
                                        input bit end_capture);
        send_byte(8'h45, 1'b0);
        send_byte(8'($urandom), 1'b0);
        send_byte(total_len[15:8], 1'b0);
        send_byte(total_len[7:0], end_capture && fill == 0);
        for (int i = 0; i < fill; i++) begin
            send_byte(8'($urandom), end_capture && i == fill - 1);
        end
        if (end_capture) begin
            captures_sent++;
        end
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(negedge clk); while (summaries_pending != 0);
    endtask

    task automatic set_idling(input bit on);
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        idle_on = on;
        @(negedge clk);
    endtask

    // well-formed packets mostly, with bad lengths, huge lengths, noise and cut captures
    task automatic build_random_capture();
        int n_pkts;
        int len;
        int r;
        int keep;
        capture_bytes.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 40)) capture_bytes.push_back(8'($urandom));
            return;
        end
        n_pkts = $urandom_range(1, 3);
        for (int p = 0; p < n_pkts; p++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                len = $urandom_range(0, 3);
            end else if (r < 10) begin
                len = $urandom_range(81, 65535);
            end else if (r < 55) begin
                len = $urandom_range(4, 32);
            end else begin
                len = $urandom_range(20, 80);
            end
            capture_bytes.push_back(8'($urandom));
            capture_bytes.push_back(8'($urandom));
            capture_bytes.push_back(len[15:8]);
            capture_bytes.push_back(len[7:0]);
            if (len < 4 || len > 80) begin
                repeat ($urandom_range(0, 40)) capture_bytes.push_back(8'($urandom));
                break;
            end
            repeat (len - 4) capture_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(9) < 2) begin
            keep = $urandom_range(1, capture_bytes.size());
            while (capture_bytes.size() > keep) void'(capture_bytes.pop_back());
        end
    endtask

    initial begin
        int rand_start;
        int rand_caps;
        rst_n             = 1'b0;
        idle_on           = 1'b1;
        rx_hold_req       = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-byte capture, zero total length, all-ones and all-zeros fields
        capture_bytes = {8'h3c};
        send_capture();
        capture_bytes = {8'h4f, 8'hff, 8'h00, 8'h00};
        send_capture();
        capture_bytes = {8'hf0, 8'h00, 8'h00, 8'h14, 8'hff, 8'hff, 8'hff, 8'hff,
                         8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'h01, 8'h7e,
                         8'h00, 8'hff, 8'h00, 8'hff};
        send_capture();
        wait_drained();

        // long receiver hold while one-byte captures keep coming
        @(posedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
        repeat (16) begin
            capture_bytes = {8'($urandom)};
            send_capture();
        end
        wait_drained();

        // no idling: minimum-length packets back to back, a malformed length, a tcp header
        set_idling(1'b0);
        for (int k = 0; k < NOIDLE_PACKETS; k++) begin
            send_header_and_fill(16'd4, 0, k == NOIDLE_PACKETS - 1);
        end
        send_header_and_fill(16'd2, BAD_LEN_FILL, 1'b1);
        send_header_and_fill(16'd44, 40, 1'b0);
        send_header_and_fill(16'd4, 0, 1'b1);
        wait_drained();
        set_idling(1'b1);

        rand_start = bytes_sent;
        rand_caps  = 0;
        while (bytes_sent < RAND_BYTES || rand_caps < RAND_SUMMARIES) begin
            build_random_capture();
            send_capture();
            rand_caps++;
            if ($urandom_range(9) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d bytes in %0d captures, %0d summaries compared",
                 bytes_sent, captures_sent, summaries_checked);
        $display("edge and malformed headers, a %0d-cycle receiver hold, %0d random bytes",
                 RX_HOLD_CYCLES, bytes_sent - rand_start);
        if (mismatches == 0 && summaries_pending == 0) begin
            $display("[ipv4_packet_stream_summary_unit] OK");
        end else begin
            $display("[ipv4_packet_stream_summary_unit] ERROR");
        end
        $finish;
    end

endmodule
